// ===== hdl/tcbl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcbl_pkg
// Shared types and constants for the two-channel breathing LED fader.
// ----------------------------------------------------------------------------
package tcbl_pkg;

    // Top duty value of the breathing ramp.
    localparam int DUTY_TOP = 255;

    localparam int CNT_W     = 16;
    localparam int DUTY_W    = 8;
    localparam int RATE_W    = 8;
    localparam int MODE_W    = 3;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    // Width of DUTY_TOP times the largest rate, and of the compare against it.
    localparam int TOP_W = $clog2(DUTY_TOP * ((1 << RATE_W) - 1) + 1);
    localparam int CMP_W = (TOP_W > CNT_W) ? TOP_W : CNT_W;

    localparam int DIV_CNT_W = $clog2(CNT_W + 1);

    // Effect modes.
    localparam logic [MODE_W-1:0] MODE_FADE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FADE_PUSH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_ON   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PUSH_OFF  = 3'd3;

    // Breathing phases.
    localparam logic [PHASE_W-1:0] PH_RAMP_UP   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HOLD_HIGH = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RAMP_DOWN = 2'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD_LOW  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_A          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_B          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_RATE_A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_RATE_B      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTEN_RATE_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTEN_RATE_B = 3'd5;

    localparam logic [RATE_W-1:0] DIM_RATE_RST      = 8'd5;
    localparam logic [RATE_W-1:0] BRIGHTEN_RATE_RST = 8'd3;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]   tick_count;
        logic [DUTY_W-1:0]  duty_level;
        logic               pin_level;
        logic               pwm_on;
    } chan_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_WAIT_A,
        ST_DIV_B,
        ST_WAIT_B,
        ST_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic keys_load;
        logic div_start;
        logic div_sel;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/tcbl_div.sv =====
// ----------------------------------------------------------------------------
// tcbl_div
// Restoring serial divider: tick count over rate, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcbl_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [tcbl_pkg::CNT_W-1:0]   dividend,
    input  logic [tcbl_pkg::RATE_W-1:0]  divisor,
    output logic [tcbl_pkg::CNT_W-1:0]   quotient,
    output logic                         done
);

    logic [tcbl_pkg::CNT_W-1:0]     quo_reg, quo_next;
    logic [tcbl_pkg::RATE_W-1:0]    rem_reg, rem_next;
    logic [tcbl_pkg::RATE_W-1:0]    dvs_reg, dvs_next;
    logic [tcbl_pkg::DIV_CNT_W-1:0] step_reg, step_next;
    logic                           done_reg, done_next;

    logic [tcbl_pkg::RATE_W:0] trial;
    logic [tcbl_pkg::RATE_W:0] diff;
    logic                      ge;

    always_comb begin
        trial = {rem_reg, quo_reg[tcbl_pkg::CNT_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = tcbl_pkg::DIV_CNT_W'(tcbl_pkg::CNT_W);
        end else if (step_reg != '0) begin
            quo_next  = {quo_reg[tcbl_pkg::CNT_W-2:0], ge};
            rem_next  = ge ? diff[tcbl_pkg::RATE_W-1:0] : trial[tcbl_pkg::RATE_W-1:0];
            step_next = step_reg - 1'b1;
            done_next = (step_reg == tcbl_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/tcbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcbl_ctrl
// Sequencer: accepts a tick, runs both divisions, then commits the update.
// ----------------------------------------------------------------------------
module tcbl_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tcbl_pkg::dp_status_t  status,
    output tcbl_pkg::ctrl_cmd_t   cmd
);

    tcbl_pkg::ctrl_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcbl_pkg::ST_IDLE: begin
                if (s_valid) state_next = tcbl_pkg::ST_DIV_A;
            end
            tcbl_pkg::ST_DIV_A:  state_next = tcbl_pkg::ST_WAIT_A;
            tcbl_pkg::ST_WAIT_A: begin
                if (status.div_done) state_next = tcbl_pkg::ST_DIV_B;
            end
            tcbl_pkg::ST_DIV_B:  state_next = tcbl_pkg::ST_WAIT_B;
            tcbl_pkg::ST_WAIT_B: begin
                if (status.div_done) state_next = tcbl_pkg::ST_COMMIT;
            end
            tcbl_pkg::ST_COMMIT: begin
                if (status.out_free) state_next = tcbl_pkg::ST_IDLE;
            end
            default: state_next = tcbl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.keys_load = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            tcbl_pkg::ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.keys_load = s_valid;
            end
            tcbl_pkg::ST_DIV_A:  cmd.div_start = 1'b1;
            tcbl_pkg::ST_WAIT_A: cmd.div_sel   = 1'b0;
            tcbl_pkg::ST_DIV_B: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
            end
            tcbl_pkg::ST_WAIT_B: cmd.div_sel = 1'b1;
            tcbl_pkg::ST_COMMIT: cmd.commit  = status.out_free;
            default: cmd.commit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcbl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/tcbl_datapath.sv =====
// ----------------------------------------------------------------------------
// tcbl_datapath
// Configuration registers, channel state, shared divider and result register.
// ----------------------------------------------------------------------------
module tcbl_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tcbl_pkg::ctrl_cmd_t              cmd,
    output tcbl_pkg::dp_status_t             status,
    input  logic                             keys_pressed,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcbl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcbl_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                             m_ready,
    output logic                             m_valid,
    output tcbl_pkg::chan_state_t            chan_a,
    output tcbl_pkg::chan_state_t            chan_b
);

    logic [tcbl_pkg::MODE_W-1:0] mode_a_reg, mode_b_reg;
    logic [tcbl_pkg::RATE_W-1:0] dim_a_reg, dim_b_reg;
    logic [tcbl_pkg::RATE_W-1:0] bri_a_reg, bri_b_reg;

    tcbl_pkg::chan_state_t ch_a_reg, ch_b_reg, ch_a_next, ch_b_next;
    logic [tcbl_pkg::CNT_W-1:0] quo_a_reg, quo_b_reg;
    logic                       keys_reg;
    logic                       m_valid_reg, m_valid_next;

    logic [tcbl_pkg::CNT_W-1:0]  div_dividend;
    logic [tcbl_pkg::RATE_W-1:0] div_divisor;
    logic [tcbl_pkg::CNT_W-1:0]  div_quotient;
    logic                        div_done;

    function automatic logic [tcbl_pkg::RATE_W-1:0] eff_rate(
        input logic [tcbl_pkg::RATE_W-1:0] r
    );
        return (r == '0) ? tcbl_pkg::RATE_W'(1) : r;
    endfunction

    // Ramp up divides by the brighten rate, every other phase by the dim rate.
    function automatic logic [tcbl_pkg::RATE_W-1:0] pick_divisor(
        input tcbl_pkg::chan_state_t       c,
        input logic [tcbl_pkg::RATE_W-1:0] dr,
        input logic [tcbl_pkg::RATE_W-1:0] br
    );
        return (c.phase == tcbl_pkg::PH_RAMP_UP) ? eff_rate(br) : eff_rate(dr);
    endfunction

    function automatic tcbl_pkg::chan_state_t chan_step(
        input tcbl_pkg::chan_state_t       cur,
        input logic [tcbl_pkg::MODE_W-1:0] mode,
        input logic [tcbl_pkg::RATE_W-1:0] dr_raw,
        input logic [tcbl_pkg::RATE_W-1:0] br_raw,
        input logic [tcbl_pkg::CNT_W-1:0]  quo,
        input logic                        keys
    );
        tcbl_pkg::chan_state_t    nxt;
        logic [tcbl_pkg::CMP_W-1:0] cnt_w;
        logic [tcbl_pkg::CMP_W-1:0] top_b;
        logic [tcbl_pkg::CMP_W-1:0] top_d;
        logic signed [tcbl_pkg::CMP_W:0] down;
        logic fading;
        nxt    = cur;
        cnt_w  = tcbl_pkg::CMP_W'(cur.tick_count);
        top_b  = tcbl_pkg::CMP_W'(tcbl_pkg::DUTY_TOP) * tcbl_pkg::CMP_W'(eff_rate(br_raw));
        top_d  = tcbl_pkg::CMP_W'(tcbl_pkg::DUTY_TOP) * tcbl_pkg::CMP_W'(eff_rate(dr_raw));
        down   = $signed({1'b0, tcbl_pkg::CMP_W'(tcbl_pkg::DUTY_TOP)})
               - $signed({1'b0, tcbl_pkg::CMP_W'(quo)});
        fading = (mode == tcbl_pkg::MODE_FADE) || (mode == tcbl_pkg::MODE_FADE_PUSH);

        if (mode == tcbl_pkg::MODE_PUSH_ON) begin
            nxt.pin_level = keys;
        end else if (mode == tcbl_pkg::MODE_PUSH_OFF) begin
            nxt.pin_level = !keys;
        end

        if (fading) begin
            case (cur.phase)
                tcbl_pkg::PH_RAMP_UP: begin
                    nxt.duty_level = (quo > tcbl_pkg::CNT_W'(255)) ? 8'hFF
                                   : quo[tcbl_pkg::DUTY_W-1:0];
                    if (cnt_w >= top_b) nxt.phase = tcbl_pkg::PH_HOLD_HIGH;
                end
                tcbl_pkg::PH_HOLD_HIGH: begin
                    if (cnt_w >= top_d) begin
                        nxt.tick_count = '0;
                        nxt.phase      = tcbl_pkg::PH_RAMP_DOWN;
                    end
                end
                tcbl_pkg::PH_RAMP_DOWN: begin
                    if (down < 0) begin
                        nxt.duty_level = '0;
                    end else if (down > 255) begin
                        nxt.duty_level = 8'hFF;
                    end else begin
                        nxt.duty_level = down[tcbl_pkg::DUTY_W-1:0];
                    end
                    if (cnt_w >= top_d) nxt.phase = tcbl_pkg::PH_HOLD_LOW;
                end
                default: begin
                    if (cnt_w >= top_b) begin
                        nxt.tick_count = '0;
                        nxt.phase      = tcbl_pkg::PH_RAMP_UP;
                    end
                end
            endcase
            nxt.pwm_on     = 1'b1;
            nxt.pin_level  = 1'b1;
            nxt.tick_count = nxt.tick_count + 1'b1;
        end else begin
            nxt.duty_level = '0;
            nxt.pwm_on     = 1'b0;
            nxt.tick_count = '0;
            nxt.phase      = tcbl_pkg::PH_RAMP_UP;
        end
        return nxt;
    endfunction

    always_comb begin
        if (cmd.div_sel) begin
            div_dividend = ch_b_reg.tick_count;
            div_divisor  = pick_divisor(ch_b_reg, dim_b_reg, bri_b_reg);
        end else begin
            div_dividend = ch_a_reg.tick_count;
            div_divisor  = pick_divisor(ch_a_reg, dim_a_reg, bri_a_reg);
        end
    end

    tcbl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_comb begin
        ch_a_next = chan_step(ch_a_reg, mode_a_reg, dim_a_reg, bri_a_reg, quo_a_reg, keys_reg);
        ch_b_next = chan_step(ch_b_reg, mode_b_reg, dim_b_reg, bri_b_reg, quo_b_reg, keys_reg);
    end

    // The result register is free once it is empty or its transaction completes now.
    assign status.out_free = !m_valid_reg || m_ready;
    assign status.div_done = div_done;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_a_reg  <= tcbl_pkg::MODE_FADE;
            mode_b_reg  <= tcbl_pkg::MODE_FADE;
            dim_a_reg   <= tcbl_pkg::DIM_RATE_RST;
            dim_b_reg   <= tcbl_pkg::DIM_RATE_RST;
            bri_a_reg   <= tcbl_pkg::BRIGHTEN_RATE_RST;
            bri_b_reg   <= tcbl_pkg::BRIGHTEN_RATE_RST;
            ch_a_reg    <= '{phase: tcbl_pkg::PH_RAMP_UP, tick_count: '0,
                             duty_level: '0, pin_level: 1'b1, pwm_on: 1'b1};
            ch_b_reg    <= '{phase: tcbl_pkg::PH_RAMP_UP, tick_count: '0,
                             duty_level: '0, pin_level: 1'b1, pwm_on: 1'b1};
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tcbl_pkg::CFG_MODE_A:
                        mode_a_reg <= cfg_data[tcbl_pkg::MODE_W-1:0];
                    tcbl_pkg::CFG_MODE_B:
                        mode_b_reg <= cfg_data[tcbl_pkg::MODE_W-1:0];
                    tcbl_pkg::CFG_DIM_RATE_A:      dim_a_reg <= cfg_data;
                    tcbl_pkg::CFG_DIM_RATE_B:      dim_b_reg <= cfg_data;
                    tcbl_pkg::CFG_BRIGHTEN_RATE_A: bri_a_reg <= cfg_data;
                    tcbl_pkg::CFG_BRIGHTEN_RATE_B: bri_b_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                ch_a_reg <= ch_a_next;
                ch_b_reg <= ch_b_next;
            end
            m_valid_reg <= m_valid_next;
        end
        if (cmd.keys_load) keys_reg <= keys_pressed;
        if (div_done && !cmd.div_sel) quo_a_reg <= div_quotient;
        if (div_done && cmd.div_sel)  quo_b_reg <= div_quotient;
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign chan_a    = ch_a_reg;
    assign chan_b    = ch_b_reg;

endmodule

// ===== hdl/two_channel_breathing_led_fader.sv =====
// ----------------------------------------------------------------------------
// two_channel_breathing_led_fader
// A tick is processed through one shared 16-step serial divider, run for each
// channel in turn; no new tick is taken until its update has been committed.
// A tick is accepted while the previous result still waits in its register.
// Reset (aresetn low, synchronous) restores config defaults and channel state.
// ----------------------------------------------------------------------------
module two_channel_breathing_led_fader (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_keys_pressed,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tcbl_pkg::DUTY_W-1:0]      m_duty_a,
    output logic [tcbl_pkg::DUTY_W-1:0]      m_duty_b,
    output logic                             m_pwm_enable_a,
    output logic                             m_pwm_enable_b,
    output logic                             m_pin_a,
    output logic                             m_pin_b,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcbl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcbl_pkg::CFG_DAT_W-1:0]   cfg_data
);

    tcbl_pkg::ctrl_cmd_t   cmd;
    tcbl_pkg::dp_status_t  status;
    tcbl_pkg::chan_state_t chan_a;
    tcbl_pkg::chan_state_t chan_b;

    tcbl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcbl_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .keys_pressed (s_keys_pressed),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .chan_a       (chan_a),
        .chan_b       (chan_b)
    );

    // Channel state only changes on commit, so it doubles as the result register.
    assign m_duty_a       = chan_a.duty_level;
    assign m_duty_b       = chan_b.duty_level;
    assign m_pwm_enable_a = chan_a.pwm_on;
    assign m_pwm_enable_b = chan_b.pwm_on;
    assign m_pin_a        = chan_a.pin_level;
    assign m_pin_b        = chan_b.pin_level;

endmodule

// ===== tb/two_channel_breathing_led_fader_tb.sv =====
// ----------------------------------------------------------------------------
// two_channel_breathing_led_fader_tb
// Drives effect ticks and register writes into the fader and checks each result
// transaction against a cycle-free model of both breathing channels (typed script
// rows: against their given values). A short scripted sequence covers modes, reset
// values and rate extremes; random segments with random rates and key patterns
// follow, under three back-pressure profiles on the tick and result channels.
// ----------------------------------------------------------------------------
module two_channel_breathing_led_fader_tb;

    localparam int DUTY_W    = tcbl_pkg::DUTY_W;
    localparam int RATE_W    = tcbl_pkg::RATE_W;
    localparam int MODE_W    = tcbl_pkg::MODE_W;
    localparam int PHASE_W   = tcbl_pkg::PHASE_W;
    localparam int CNT_W     = tcbl_pkg::CNT_W;
    localparam int CFG_IDX_W = tcbl_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = tcbl_pkg::CFG_DAT_W;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;
    localparam int DUTY_MAX     = (1 << DUTY_W) - 1;
    localparam int RATE_MAX     = (1 << RATE_W) - 1;

    // Modes with no name in the package: 4 is "other", 5 to 7 are undefined.
    localparam logic [MODE_W-1:0] MODE_OTHER   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_UNDEF_5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_UNDEF_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF_7 = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic              pwm_enable_a;
        logic              pwm_enable_b;
        logic              pin_a;
        logic              pin_b;
    } led_result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [RATE_W-1:0]  dim_rate;
        logic [RATE_W-1:0]  brighten_rate;
        logic [PHASE_W-1:0] phase;
        logic [CNT_W-1:0]   tick_count;
        logic [DUTY_W-1:0]  duty_level;
        logic               pin_level;
        logic               pwm_on;
    } lamp_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TICK,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DAT_W-1:0]   data;
        logic                   keys;
        led_result_t            want;
    } script_row_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic                 s_keys_pressed = 1'b0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [DUTY_W-1:0]    m_duty_a;
    logic [DUTY_W-1:0]    m_duty_b;
    logic                 m_pwm_enable_a;
    logic                 m_pwm_enable_b;
    logic                 m_pin_a;
    logic                 m_pin_b;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_DAT_W-1:0] cfg_data       = '0;

    lamp_t         lamp [2];
    led_result_t   expected_leds [$];
    script_row_t   script [$];
    int            error_count  = 0;
    int            cycle_count  = 0;
    int            gap_pct      = 36;
    int            stall_pct    = 80;
    int            random_items = 0;

    logic [CFG_IDX_W-1:0] reg_order [6] = '{tcbl_pkg::CFG_MODE_A, tcbl_pkg::CFG_MODE_B,
                                           tcbl_pkg::CFG_DIM_RATE_A,
                                           tcbl_pkg::CFG_DIM_RATE_B,
                                           tcbl_pkg::CFG_BRIGHTEN_RATE_A,
                                           tcbl_pkg::CFG_BRIGHTEN_RATE_B};

    two_channel_breathing_led_fader DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_keys_pressed (s_keys_pressed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_duty_a       (m_duty_a),
        .m_duty_b       (m_duty_b),
        .m_pwm_enable_a (m_pwm_enable_a),
        .m_pwm_enable_b (m_pwm_enable_b),
        .m_pin_a        (m_pin_a),
        .m_pin_b        (m_pin_b),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [DUTY_W-1:0] clip_duty(input int level);
        if (level < 0) return '0;
        if (level > DUTY_MAX) return DUTY_W'(DUTY_MAX);
        return level[DUTY_W-1:0];
    endfunction

    // One effect tick on one channel: key handling first, then the fader.
    function automatic lamp_t breathe_channel(input lamp_t c, input logic keys);
        int br;
        int dr;
        int cnt;
        br  = (c.brighten_rate == '0) ? 1 : int'(c.brighten_rate);
        dr  = (c.dim_rate == '0) ? 1 : int'(c.dim_rate);
        cnt = int'(c.tick_count);
        if (c.mode == tcbl_pkg::MODE_FADE_PUSH || c.mode == tcbl_pkg::MODE_PUSH_ON) begin
            c.pin_level = keys;
        end else if (c.mode == tcbl_pkg::MODE_PUSH_OFF) begin
            if (keys) begin
                c.duty_level = '0;
                c.pwm_on     = 1'b0;
                c.pin_level  = 1'b0;
            end else begin
                c.pin_level = 1'b1;
            end
        end
        if (c.mode != tcbl_pkg::MODE_FADE && c.mode != tcbl_pkg::MODE_FADE_PUSH) begin
            c.duty_level = '0;
            c.pwm_on     = 1'b0;
            c.tick_count = '0;
            c.phase      = tcbl_pkg::PH_RAMP_UP;
            return c;
        end
        // Thresholds are compared against the count as it was on entry.
        case (c.phase)
            tcbl_pkg::PH_RAMP_UP: begin
                c.duty_level = clip_duty(cnt / br);
                if (cnt >= tcbl_pkg::DUTY_TOP * br) c.phase = tcbl_pkg::PH_HOLD_HIGH;
            end
            tcbl_pkg::PH_HOLD_HIGH: begin
                if (cnt >= tcbl_pkg::DUTY_TOP * dr) begin
                    c.tick_count = '0;
                    c.phase      = tcbl_pkg::PH_RAMP_DOWN;
                end
            end
            tcbl_pkg::PH_RAMP_DOWN: begin
                c.duty_level = clip_duty(tcbl_pkg::DUTY_TOP - cnt / dr);
                if (cnt >= tcbl_pkg::DUTY_TOP * dr) c.phase = tcbl_pkg::PH_HOLD_LOW;
            end
            default: begin
                if (cnt >= tcbl_pkg::DUTY_TOP * br) begin
                    c.tick_count = '0;
                    c.phase      = tcbl_pkg::PH_RAMP_UP;
                end
            end
        endcase
        c.pwm_on     = 1'b1;
        c.pin_level  = 1'b1;
        c.tick_count = c.tick_count + 1'b1;
        return c;
    endfunction

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DAT_W-1:0] data);
        script_row_t row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.index = index;
        row.data  = data;
        script.push_back(row);
    endtask

    task automatic add_tick(input logic keys);
        script_row_t row;
        row      = '0;
        row.kind = ROW_TICK;
        row.keys = keys;
        script.push_back(row);
    endtask

    task automatic add_typed(input logic keys, input int duty_a, input int duty_b,
                             input logic en_a, input logic en_b,
                             input logic pin_a, input logic pin_b);
        script_row_t row;
        row                   = '0;
        row.kind              = ROW_TYPED;
        row.keys              = keys;
        row.want.duty_a       = DUTY_W'(duty_a);
        row.want.duty_b       = DUTY_W'(duty_b);
        row.want.pwm_enable_a = en_a;
        row.want.pwm_enable_b = en_b;
        row.want.pin_a        = pin_a;
        row.want.pin_b        = pin_b;
        script.push_back(row);
    endtask

    // The caller lowers cfg_valid once the batch of writes is done.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            tcbl_pkg::CFG_MODE_A:          lamp[0].mode          = data[MODE_W-1:0];
            tcbl_pkg::CFG_MODE_B:          lamp[1].mode          = data[MODE_W-1:0];
            tcbl_pkg::CFG_DIM_RATE_A:      lamp[0].dim_rate      = data[RATE_W-1:0];
            tcbl_pkg::CFG_DIM_RATE_B:      lamp[1].dim_rate      = data[RATE_W-1:0];
            tcbl_pkg::CFG_BRIGHTEN_RATE_A: lamp[0].brighten_rate = data[RATE_W-1:0];
            tcbl_pkg::CFG_BRIGHTEN_RATE_B: lamp[1].brighten_rate = data[RATE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic keys, input logic typed, input led_result_t want);
        led_result_t predicted;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_keys_pressed <= keys;
        do @(posedge aclk); while (!s_ready);
        lamp[0] = breathe_channel(lamp[0], keys);
        lamp[1] = breathe_channel(lamp[1], keys);
        predicted.duty_a       = lamp[0].duty_level;
        predicted.duty_b       = lamp[1].duty_level;
        predicted.pwm_enable_a = lamp[0].pwm_on;
        predicted.pwm_enable_b = lamp[1].pwm_on;
        predicted.pin_a        = lamp[0].pin_level;
        predicted.pin_b        = lamp[1].pin_level;
        expected_leds.push_back(typed ? want : predicted);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_leds.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("two_channel_breathing_led_fader: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        led_result_t got;
        led_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.duty_a       = m_duty_a;
            got.duty_b       = m_duty_b;
            got.pwm_enable_a = m_pwm_enable_a;
            got.pwm_enable_b = m_pwm_enable_b;
            got.pin_a        = m_pin_a;
            got.pin_b        = m_pin_b;
            if (expected_leds.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result transaction: duty %0d/%0d pwm %b%b pin %b%b",
                             got.duty_a, got.duty_b, got.pwm_enable_a, got.pwm_enable_b,
                             got.pin_a, got.pin_b);
            end else begin
                want = expected_leds.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"result differs: expected duty %0d/%0d pwm %b%b pin %b%b,",
                                  " got duty %0d/%0d pwm %b%b pin %b%b"},
                                 want.duty_a, want.duty_b, want.pwm_enable_a,
                                 want.pwm_enable_b, want.pin_a, want.pin_b,
                                 got.duty_a, got.duty_b, got.pwm_enable_a,
                                 got.pwm_enable_b, got.pin_a, got.pin_b);
                end
            end
        end
    end

    initial begin
        int          seg_len;
        int          key_bias;
        int          pick;
        logic [CFG_DAT_W-1:0] data;

        for (int i = 0; i < 2; i++) begin
            lamp[i]               = '0;
            lamp[i].mode          = tcbl_pkg::MODE_FADE;
            lamp[i].dim_rate      = tcbl_pkg::DIM_RATE_RST;
            lamp[i].brighten_rate = tcbl_pkg::BRIGHTEN_RATE_RST;
            lamp[i].phase         = tcbl_pkg::PH_RAMP_UP;
            lamp[i].pin_level     = 1'b1;
            lamp[i].pwm_on        = 1'b1;
        end

        // Reset values, the push modes, undefined modes and zero/full rates.
        add_typed(1'b0, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1);
        add_typed(1'b1, 0, 0, 1'b1, 1'b1, 1'b1, 1'b1);
        add_cfg(tcbl_pkg::CFG_MODE_A, CFG_DAT_W'(tcbl_pkg::MODE_PUSH_OFF));
        add_cfg(tcbl_pkg::CFG_MODE_B, CFG_DAT_W'(tcbl_pkg::MODE_PUSH_ON));
        add_typed(1'b1, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1);
        add_typed(1'b0, 0, 0, 1'b0, 1'b0, 1'b1, 1'b0);
        add_cfg(tcbl_pkg::CFG_MODE_A, CFG_DAT_W'(tcbl_pkg::MODE_FADE_PUSH));
        add_cfg(tcbl_pkg::CFG_MODE_B, CFG_DAT_W'(MODE_UNDEF_7));
        add_typed(1'b0, 0, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        add_tick(1'b1);
        add_cfg(tcbl_pkg::CFG_DIM_RATE_A, '0);
        add_cfg(tcbl_pkg::CFG_BRIGHTEN_RATE_A, '0);
        add_cfg(tcbl_pkg::CFG_DIM_RATE_B, CFG_DAT_W'(RATE_MAX));
        add_cfg(tcbl_pkg::CFG_BRIGHTEN_RATE_B, CFG_DAT_W'(RATE_MAX));
        add_cfg(tcbl_pkg::CFG_MODE_B, CFG_DAT_W'(tcbl_pkg::MODE_FADE));
        add_tick(1'b1);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b1);
        add_cfg(tcbl_pkg::CFG_MODE_A, CFG_DAT_W'(MODE_UNDEF_5));
        add_cfg(tcbl_pkg::CFG_MODE_B, CFG_DAT_W'(MODE_UNDEF_6));
        add_tick(1'b1);
        add_tick(1'b0);
        add_cfg(tcbl_pkg::CFG_MODE_A, CFG_DAT_W'(MODE_OTHER));
        add_cfg(tcbl_pkg::CFG_MODE_B, CFG_DAT_W'(tcbl_pkg::MODE_PUSH_OFF));
        add_tick(1'b1);
        add_tick(1'b0);
        add_cfg(tcbl_pkg::CFG_MODE_A, CFG_DAT_W'(tcbl_pkg::MODE_FADE));
        add_cfg(tcbl_pkg::CFG_MODE_B, CFG_DAT_W'(tcbl_pkg::MODE_FADE_PUSH));
        add_cfg(tcbl_pkg::CFG_DIM_RATE_A, 8'd1);
        add_cfg(tcbl_pkg::CFG_BRIGHTEN_RATE_A, 8'd1);
        add_cfg(tcbl_pkg::CFG_DIM_RATE_B, 8'd1);
        add_cfg(tcbl_pkg::CFG_BRIGHTEN_RATE_B, 8'd1);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b0);
        add_tick(1'b1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_CFG) begin
                settle();
                write_register(script[i].index, script[i].data);
            end else begin
                cfg_valid <= 1'b0;
                send_tick(script[i].keys, script[i].kind == ROW_TYPED, script[i].want);
            end
        end

        // Rates change only between segments, most often to 1, so the breathing cycle
        // can run through all four phases; a rate drop mid-cycle saturates duty.
        while (random_items < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 99) < 65) begin
                foreach (reg_order[r]) begin
                    if ($urandom_range(0, 99) < 40) begin
                        pick = $urandom_range(0, 19);
                        if (reg_order[r] == tcbl_pkg::CFG_MODE_A
                                || reg_order[r] == tcbl_pkg::CFG_MODE_B) begin
                            if (pick < 9) data = CFG_DAT_W'(tcbl_pkg::MODE_FADE);
                            else if (pick < 16) data = CFG_DAT_W'(tcbl_pkg::MODE_FADE_PUSH);
                            else data = CFG_DAT_W'($urandom_range(tcbl_pkg::MODE_PUSH_ON,
                                                                  MODE_UNDEF_7));
                        end else begin
                            if (pick < 10) data = 8'd1;
                            else if (pick < 13) data = CFG_DAT_W'($urandom_range(2, 3));
                            else if (pick < 15) data = '0;
                            else if (pick < 16) data = CFG_DAT_W'(RATE_MAX);
                            else data = CFG_DAT_W'($urandom_range(0, RATE_MAX));
                        end
                        write_register(reg_order[r], data);
                    end
                end
                cfg_valid <= 1'b0;
            end
            seg_len  = $urandom_range(30, 250);
            if (seg_len > RANDOM_ITEMS - random_items) seg_len = RANDOM_ITEMS - random_items;
            key_bias = $urandom_range(0, 100);
            repeat (seg_len) begin
                case (random_items * 3 / RANDOM_ITEMS)
                    0: begin
                        gap_pct   = 36;
                        stall_pct = 80;
                    end
                    1: begin
                        gap_pct   = 80;
                        stall_pct = 36;
                    end
                    default: begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end
                endcase
                send_tick($urandom_range(0, 99) < key_bias, 1'b0, '0);
                random_items++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("two_channel_breathing_led_fader: match");
        end else begin
            $display("two_channel_breathing_led_fader: mismatch");
        end
        $finish;
    end

endmodule
